/* rtl/b64ve_pkg.sv */
// Shared types, constants and the symbol alphabet for the base64 variant encoder.
package b64ve_pkg;

  localparam int unsigned IdxW     = 7;   // 0..63 plus the pad index
  localparam int unsigned SymW     = 7;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);
  localparam logic [IdxW-1:0] PadIdx = 7'd64;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [SymW-1:0] sym_t;

  // one encoded group: four alphabet indices and the message-end flag
  typedef struct packed {
    idx_t [3:0] idx;
    logic       fin;
  } group_t;

  // front to queue
  typedef struct packed {
    logic   push;
    group_t grp;
  } push_t;

  // queue status and read data
  typedef struct packed {
    logic   full;
    logic   avail;
    group_t grp;
  } qstat_t;

  // alphabet: A-Z, a-z, 1..9, 0, +, /, and = for padding
  function automatic sym_t idx_to_sym(idx_t idx);
    sym_t s;
    case (idx) inside
      [7'd0:7'd25]:  s = SymW'(7'd65 + idx);          // 'A'..'Z'
      [7'd26:7'd51]: s = SymW'(7'd97 + (idx - 7'd26)); // 'a'..'z'
      [7'd52:7'd60]: s = SymW'(7'd49 + (idx - 7'd52)); // '1'..'9'
      7'd61:         s = 7'd48;                        // '0'
      7'd62:         s = 7'd43;                        // '+'
      7'd63:         s = 7'd47;                        // '/'
      default:       s = 7'd61;                        // '='
    endcase
    return s;
  endfunction

endpackage

/* rtl/b64ve_front.sv */
// Front end: gathers bytes into groups of three and builds the four indices.
module b64ve_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_is_final,
  input  logic                   q_full,
  output b64ve_pkg::push_t       push
);

  logic [1:0][7:0] held_r, held_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            accept;
  logic            close;
  logic [7:0]      b0, b1, b2;
  logic [1:0]      cnt;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  // count of 3 never occurs; treat it as 2
  assign cnt      = (cnt_r == 2'd3) ? 2'd2 : cnt_r;
  assign close    = in_is_final || (cnt == 2'd2);

  always_comb begin
    b0 = (cnt == 2'd0) ? in_data_byte : held_r[0];
    b1 = (cnt == 2'd1) ? in_data_byte : ((cnt == 2'd2) ? held_r[1] : 8'h00);
    b2 = (cnt == 2'd2) ? in_data_byte : 8'h00;

    push.push       = accept && close;
    push.grp.fin    = in_is_final;
    push.grp.idx[0] = {1'b0, b0[5:0]};
    push.grp.idx[1] = {1'b0, b1[3:0], b0[7:6]};
    push.grp.idx[2] = (cnt != 2'd0) ? {1'b0, b2[1:0], b1[7:4]} : b64ve_pkg::PadIdx;
    push.grp.idx[3] = (cnt == 2'd2) ? {1'b0, b2[7:2]} : b64ve_pkg::PadIdx;
  end

  always_comb begin
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (close) begin
        held_nxt = '0;
        cnt_nxt  = 2'd0;
      end else begin
        held_nxt[cnt[0]] = in_data_byte;
        cnt_nxt          = cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      cnt_r  <= 2'd0;
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* rtl/b64ve_queue.sv */
// Short group queue between the front end and the symbol serializer.
module b64ve_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  b64ve_pkg::push_t   push,
  input  logic               pop,
  output b64ve_pkg::qstat_t  stat
);

  b64ve_pkg::group_t mem_r [b64ve_pkg::QDepth];
  logic [b64ve_pkg::QPtrW-1:0] wr_r, rd_r;
  logic [b64ve_pkg::QCntW-1:0] cnt_r;
  logic                        do_push, do_pop;

  assign do_push = push.push && (cnt_r != b64ve_pkg::QCntW'(b64ve_pkg::QDepth));
  assign do_pop  = pop && (cnt_r != '0);

  assign stat.full  = (cnt_r == b64ve_pkg::QCntW'(b64ve_pkg::QDepth));
  assign stat.avail = (cnt_r != '0);
  assign stat.grp   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= b64ve_pkg::QPtrW'(wr_r + 1'b1);
      end
      if (do_pop) begin
        rd_r <= b64ve_pkg::QPtrW'(rd_r + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/b64ve_back.sv */
// Back end: sends the four symbols of each queued group through an output register.
module b64ve_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  b64ve_pkg::qstat_t      stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [6:0]             out_symbol,
  output logic                   out_group_end,
  output logic                   out_message_end
);

  logic [1:0]           sel_r, sel_nxt;
  logic                 vld_r, vld_nxt;
  b64ve_pkg::sym_t      sym_r, sym_nxt;
  logic                 gend_r, gend_nxt;
  logic                 mend_r, mend_nxt;
  logic                 load;
  logic                 last;

  // output register is free when empty or its symbol transfers this cycle
  assign load = stat.avail && (!vld_r || !out_stall);
  assign last = (sel_r == 2'd3);
  assign pop  = load && last;

  always_comb begin
    sel_nxt  = sel_r;
    vld_nxt  = vld_r;
    sym_nxt  = sym_r;
    gend_nxt = gend_r;
    mend_nxt = mend_r;
    if (load) begin
      sel_nxt  = sel_r + 2'd1;
      vld_nxt  = 1'b1;
      sym_nxt  = b64ve_pkg::idx_to_sym(stat.grp.idx[sel_r]);
      gend_nxt = last;
      mend_nxt = last && stat.grp.fin;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    gend_r <= gend_nxt;
    mend_r <= mend_nxt;
  end

  assign out_valid       = vld_r;
  assign out_symbol      = sym_r;
  assign out_group_end   = gend_r;
  assign out_message_end = mend_r;

endmodule

/* rtl/base64_variant_encoder.sv */
// Top level of the base64 variant encoder: front end, group queue, symbol serializer.
// After the closing byte's transfer, its group is written into the queue and its first symbol
// is then loaded into the output register, which raises out_valid.
// Throughput: one byte per cycle in while the queue has room, and one symbol per cycle
// out while out_stall is low; the single output register sends the four symbols in turn.
// The 2-entry group queue lets the front end keep taking bytes while symbols drain.
// Reset (synchronous, rst_n low) empties the queue, drops held bytes and clears out_valid.
module base64_variant_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_symbol,
  output logic       out_group_end,
  output logic       out_message_end
);

  b64ve_pkg::push_t  push;
  b64ve_pkg::qstat_t stat;
  logic              pop;

  b64ve_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_is_final  (in_is_final),
    .q_full       (stat.full),
    .push         (push)
  );

  b64ve_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (stat)
  );

  b64ve_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .stat            (stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_group_end   (out_group_end),
    .out_message_end (out_message_end)
  );

  a_mend_on_gend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_group_end)
    else $error("message end without group end");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.push |-> !stat.full)
    else $error("group pushed into full queue");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.avail)
    else $error("group popped from empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
